// ----- hw/rtl/rp_pkg.sv -----
// Shared types, constants and fill-level helpers for the 48/96 to 128-bit result packer.
// Used by rp_front, rp_queue, rp_back and the top level; no dependencies.
package rp_pkg;

  localparam int PIX_W   = 48;
  localparam int HALF_W  = 64;
  localparam int WORD_W  = 128;
  localparam int HOLD_W  = 112;
  localparam int FILL_W  = 7;
  localparam int PHASE_W = 3;

  localparam logic [7:0] WIDTH_THIRD = 8'd48;
  localparam logic [7:0] WIDTH_HALF  = 8'd96;
  localparam logic [7:0] WORD_BITS   = 8'd128;
  localparam logic [PHASE_W-1:0] HALF_LAST_PHASE = 3'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [0:0] REG_IDX_THIRD_MODE = 1'b0;

  typedef struct packed {
    logic [PIX_W-1:0] pixels_lo;
    logic [PIX_W-1:0] pixels_hi;
    logic             frame_last;
  } pix_item_t;

  typedef struct packed {
    logic [HALF_W-1:0] word_lo;
    logic [HALF_W-1:0] word_hi;
    logic              final_word;
  } word_item_t;

  // One queued input's work: an optional full word and an optional flush tail.
  typedef struct packed {
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] tail;
    logic              has_full;
    logic              has_tail;
    logic              last;
  } pack_entry_t;

  function automatic logic [FILL_W-1:0] fill_of(input logic [PHASE_W-1:0] phase,
                                                input logic third);
    logic [FILL_W-1:0] f;
    f = '0;
    if (third) begin
      case (phase)
        3'd0: f = 7'd0;
        3'd1: f = 7'd48;
        3'd2: f = 7'd96;
        3'd3: f = 7'd16;
        3'd4: f = 7'd64;
        3'd5: f = 7'd112;
        3'd6: f = 7'd32;
        3'd7: f = 7'd80;
        default: f = 7'd0;
      endcase
    end else begin
      case (phase)
        3'd0: f = 7'd0;
        3'd1: f = 7'd96;
        3'd2: f = 7'd64;
        default: f = 7'd32;
      endcase
    end
    return f;
  endfunction

  function automatic logic [WORD_W-1:0] low_mask(input logic [FILL_W-1:0] n);
    return (WORD_W'(1) << n) - WORD_W'(1);
  endfunction

endpackage

// ----- hw/rtl/rp_front.sv -----
// Front end of the result packer: accepts input items, tracks the fill phase and
// leftover bits, and builds the full word and flush tail each item produces. Uses rp_pkg.
module rp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                third_mode,
  input  logic                accept,
  input  rp_pkg::pix_item_t   item,
  output logic                entry_valid,
  output rp_pkg::pack_entry_t entry
);

  logic [rp_pkg::HOLD_W-1:0]  leftover;
  logic [rp_pkg::HOLD_W-1:0]  leftover_next;
  logic [rp_pkg::PHASE_W-1:0] phase;
  logic [rp_pkg::PHASE_W-1:0] phase_next;

  logic [rp_pkg::FILL_W-1:0]  fill;
  logic [7:0]                 width;
  logic [7:0]                 shr_amt;
  logic [rp_pkg::WORD_W-1:0]  r;
  logic [rp_pkg::WORD_W-1:0]  hold_m;
  logic [rp_pkg::WORD_W-1:0]  comb;
  logic [rp_pkg::WORD_W-1:0]  hold_full;
  logic [rp_pkg::HOLD_W-1:0]  hold;
  logic [rp_pkg::PHASE_W-1:0] adv_phase;
  logic                       has_full;
  logic                       has_tail;

  always_comb begin
    fill  = rp_pkg::fill_of(phase, third_mode);
    width = third_mode ? rp_pkg::WIDTH_THIRD : rp_pkg::WIDTH_HALF;
    if (third_mode) begin
      r = {80'b0, item.pixels_lo};
    end else begin
      r = {32'b0, item.pixels_hi, item.pixels_lo};
    end
    hold_m   = {16'b0, leftover} & rp_pkg::low_mask(fill);
    comb     = hold_m | (r << fill);
    has_full = ({1'b0, fill} + width) >= rp_pkg::WORD_BITS;
    shr_amt  = rp_pkg::WORD_BITS - {1'b0, fill};
    // A full word leaves only the input bits that did not fit.
    hold_full = has_full ? (r >> shr_amt) : comb;
    hold      = hold_full[rp_pkg::HOLD_W-1:0];

    if (third_mode) begin
      adv_phase = phase + 3'd1;
    end else if (phase >= rp_pkg::HALF_LAST_PHASE) begin
      adv_phase = '0;
    end else begin
      adv_phase = phase + 3'd1;
    end

    has_tail = item.frame_last && (adv_phase != '0);

    entry.word0    = comb;
    entry.tail     = {16'b0, hold} & rp_pkg::low_mask(rp_pkg::fill_of(adv_phase, third_mode));
    entry.has_full = has_full;
    entry.has_tail = has_tail;
    entry.last     = item.frame_last;
    entry_valid    = accept && (has_full || has_tail);

    leftover_next = leftover;
    phase_next    = phase;
    if (accept) begin
      // Drop everything at the end of a frame.
      if (item.frame_last) begin
        leftover_next = '0;
        phase_next    = '0;
      end else begin
        leftover_next = hold;
        phase_next    = adv_phase;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover <= '0;
      phase    <= '0;
    end else begin
      leftover <= leftover_next;
      phase    <= phase_next;
    end
  end

endmodule

// ----- hw/rtl/rp_queue.sv -----
// Short entry queue between the packer front and back ends.
// Flop-based storage, one write and one head read per cycle. Uses rp_pkg.
module rp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  rp_pkg::pack_entry_t wr_data,
  input  logic                rd_en,
  output rp_pkg::pack_entry_t head,
  output logic                head_valid,
  output logic                full
);

  rp_pkg::pack_entry_t mem [rp_pkg::QDEPTH];

  logic [rp_pkg::QPTR_W-1:0] wr_ptr;
  logic [rp_pkg::QPTR_W-1:0] rd_ptr;
  logic [rp_pkg::QCNT_W-1:0] count;

  assign head       = mem[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == rp_pkg::QCNT_W'(rp_pkg::QDEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= rp_pkg::QPTR_W'(wr_ptr + 1'b1);
      end
      if (rd_en) begin
        rd_ptr <= rp_pkg::QPTR_W'(rd_ptr + 1'b1);
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= rp_pkg::QCNT_W'(rp_pkg::QDEPTH))
    else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full && !rd_en))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> head_valid)
    else $error("queue read while empty");

endmodule

// ----- hw/rtl/rp_back.sv -----
// Back end of the result packer: drains queued entries into the output register,
// one 128-bit word per cycle while the receiver pops, full word before flush tail. Uses rp_pkg.
module rp_back (
  input  logic                clk,
  input  logic                rst,
  input  rp_pkg::pack_entry_t head,
  input  logic                head_valid,
  output logic                rd_en,
  input  logic                pop,
  output logic                empty,
  output rp_pkg::word_item_t  packed_word
);

  logic               out_valid;
  logic               out_valid_next;
  rp_pkg::word_item_t out_word;
  rp_pkg::word_item_t out_word_next;
  logic               sent_full;
  logic               sent_full_next;
  logic               load;

  assign empty       = !out_valid;
  assign packed_word = out_word;

  always_comb begin
    load           = !out_valid || pop;
    out_valid_next = out_valid && !pop;
    out_word_next  = out_word;
    sent_full_next = sent_full;
    rd_en          = 1'b0;
    if (load && head_valid) begin
      out_valid_next = 1'b1;
      if (head.has_full && !sent_full) begin
        out_word_next.word_lo    = head.word0[63:0];
        out_word_next.word_hi    = head.word0[127:64];
        out_word_next.final_word = head.last && !head.has_tail;
        // Hold the entry while its tail still has to go out.
        if (head.has_tail) begin
          sent_full_next = 1'b1;
        end else begin
          rd_en = 1'b1;
        end
      end else begin
        out_word_next.word_lo    = head.tail[63:0];
        out_word_next.word_hi    = head.tail[127:64];
        out_word_next.final_word = head.last;
        sent_full_next           = 1'b0;
        rd_en                    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sent_full <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      sent_full <= sent_full_next;
    end
  end

  always_ff @(posedge clk) begin
    out_word <= out_word_next;
  end

  a_split_pending: assert property (@(posedge clk) disable iff (rst)
    sent_full |-> (head_valid && head.has_tail && head.has_full))
    else $error("tail pending without a matching queue entry");

endmodule

// ----- hw/rtl/result_packer_48_96_to_128_top.sv -----
// Top level of the 48/96 to 128-bit result packer: config register, front end,
// entry queue and back end. Uses rp_pkg, rp_front, rp_queue, rp_back.
//
// Usage: the input side is a queue write port (push/full). Each transaction carries
// 48 valid bits in pixels_lo (third_mode = 1) or 96 bits in pixels_lo/pixels_hi
// (third_mode = 0), least significant bits packed first. Results come out of a queue
// read port (empty/pop) as 128-bit words; final_word marks the last word of a frame.
// An input with frame_last set flushes any partial word, zero-padded above its valid
// bits, and the packer starts the next frame empty.
// Throughput: one input per cycle while full is low, one output word per cycle while
// the receiver pops. An accepted word goes via the entry queue to the output register.
// A frame_last input that completes a word with bits left over puts out two words.
// When the receiver stalls, words wait in the output register and a four-entry queue;
// full rises once that queue fills and falls right after a pop that frees an entry
// (an entry holding a full word and a tail frees only after its second word).
// Reset (rst, synchronous) empties the queue and output, clears the fill phase and the
// hold register, and sets third_mode to 0. The user must write third_mode through
// the APB port (paddr[2] = 0) only while idle; the block does not enforce this.
module result_packer_48_96_to_128_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  rp_pkg::pix_item_t          pixel_data,
  output logic                       empty,
  input  logic                       pop,
  output rp_pkg::word_item_t         packed_word,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rp_pkg::PADDR_W-1:0] paddr,
  input  logic [rp_pkg::PDATA_W-1:0] pwdata,
  output logic [rp_pkg::PDATA_W-1:0] prdata,
  output logic                       pready
);

  logic                third_mode;
  logic                accept;
  logic                entry_valid;
  rp_pkg::pack_entry_t entry;
  rp_pkg::pack_entry_t head;
  logic                head_valid;
  logic                rd_en;
  logic                q_full;

  assign pready = 1'b1;
  assign full   = q_full;
  assign accept = push && !q_full;

  always_comb begin
    prdata = '0;
    if (paddr[2] == rp_pkg::REG_IDX_THIRD_MODE) begin
      prdata = {{(rp_pkg::PDATA_W-1){1'b0}}, third_mode};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      third_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == rp_pkg::REG_IDX_THIRD_MODE)) begin
      third_mode <= pwdata[0];
    end
  end

  rp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .third_mode  (third_mode),
    .accept      (accept),
    .item        (pixel_data),
    .entry_valid (entry_valid),
    .entry       (entry)
  );

  rp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (entry_valid),
    .wr_data    (entry),
    .rd_en      (rd_en),
    .head       (head),
    .head_valid (head_valid),
    .full       (q_full)
  );

  rp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .rd_en       (rd_en),
    .pop         (pop),
    .empty       (empty),
    .packed_word (packed_word)
  );

endmodule

// ----- sim/tb_result_packer_48_96_to_128_top.sv -----
// Self-checking testbench for result_packer_48_96_to_128_top: directed table, then random frames.
// Predicts packed 128-bit words from each accepted pixel transaction; depends on rp_pkg and the RTL.
`timescale 1ns / 100ps

module tb_result_packer_48_96_to_128_top;

  localparam int IDLE_PCT = 36;
  localparam int RANDOM_ITEMS = 1200;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;
  localparam logic [rp_pkg::PADDR_W-1:0] MODE_ADDR =
    rp_pkg::PADDR_W'(rp_pkg::REG_IDX_THIRD_MODE) << 2;
  localparam logic [47:0] ONES48 = '1;
  localparam logic [63:0] ONES64 = '1;

  typedef struct packed {
    logic               third;
    rp_pkg::pix_item_t  item;
    logic               has_want;
    rp_pkg::word_item_t want;
  } plan_row_t;

  localparam int N_ROWS = 24;
  localparam plan_row_t DIRECTED [N_ROWS] = '{
    '{1'b0, '{ONES48, ONES48, 1'b1}, 1'b1, '{ONES64, 64'h0000_0000_FFFF_FFFF, 1'b1}},
    '{1'b0, '{48'd0, 48'd0, 1'b1}, 1'b1, '{64'd0, 64'd0, 1'b1}},
    '{1'b0, '{ONES48, 48'd0, 1'b0}, 1'b0, '0},
    '{1'b0, '{48'd0, ONES48, 1'b0}, 1'b0, '0},
    '{1'b0, '{48'h1234_5678_9ABC, 48'hFEDC_BA98_7654, 1'b0}, 1'b0, '0},
    '{1'b0, '{48'h8000_0000_0001, 48'h8000_0000_0001, 1'b0}, 1'b0, '0},
    '{1'b0, '{ONES48, ONES48, 1'b0}, 1'b0, '0},
    '{1'b0, '{48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 1'b1}, 1'b0, '0},
    '{1'b0, '{ONES48, 48'd0, 1'b0}, 1'b0, '0},
    // switch to third mode with a partial half-mode word held
    '{1'b1, '{48'h0F0F_0F0F_0F0F, ONES48, 1'b0}, 1'b0, '0},
    '{1'b1, '{ONES48, ONES48, 1'b0}, 1'b0, '0},
    '{1'b1, '{48'd0, ONES48, 1'b0}, 1'b0, '0},
    '{1'b1, '{48'hC3C3_C3C3_C3C3, 48'd0, 1'b0}, 1'b0, '0},
    '{1'b1, '{48'h0000_0000_0001, 48'd0, 1'b0}, 1'b0, '0},
    '{1'b1, '{48'h8000_0000_0000, 48'd0, 1'b1}, 1'b0, '0},
    '{1'b1, '{ONES48, 48'd0, 1'b1}, 1'b1, '{64'h0000_FFFF_FFFF_FFFF, 64'd0, 1'b1}},
    '{1'b1, '{48'd0, 48'd0, 1'b1}, 1'b1, '{64'd0, 64'd0, 1'b1}},
    '{1'b1, '{48'h0123_4567_89AB, 48'd0, 1'b0}, 1'b0, '0},
    '{1'b1, '{48'hFEDC_BA98_7654, 48'd0, 1'b0}, 1'b0, '0},
    '{1'b1, '{ONES48, 48'd0, 1'b0}, 1'b0, '0},
    '{1'b1, '{48'h5A5A_5A5A_5A5A, 48'd0, 1'b0}, 1'b0, '0},
    '{1'b1, '{48'hA5A5_A5A5_A5A5, 48'd0, 1'b0}, 1'b0, '0},
    // half mode entered at a phase it never reaches on its own
    '{1'b0, '{ONES48, ONES48, 1'b1}, 1'b0, '0},
    '{1'b0, '{48'h0F1E_2D3C_4B5A, ONES48, 1'b1}, 1'b0, '0}
  };

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        push = 1'b0;
  logic                        full;
  rp_pkg::pix_item_t           pixel_data = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  rp_pkg::word_item_t          packed_word;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [rp_pkg::PADDR_W-1:0]  paddr = '0;
  logic [rp_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [rp_pkg::PDATA_W-1:0]  prdata;
  logic                        pready;

  // predictor state
  logic                        mode_third = 1'b0;
  logic [rp_pkg::HOLD_W-1:0]   held_bits = '0;
  logic [rp_pkg::PHASE_W-1:0]  held_phase = '0;
  rp_pkg::word_item_t          words_due [$];

  int                          errors = 0;
  int                          stalled_cycles = 0;
  bit                          calm = 1'b0;

  result_packer_48_96_to_128_top dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .pixel_data  (pixel_data),
    .empty       (empty),
    .pop         (pop),
    .packed_word (packed_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [127:0] got,
                               input logic [127:0] want);
    if (errors < 50) $display("MISMATCH %s: got %h want %h", what, got, want);
    errors++;
  endtask

  // Fill level advances by the input width modulo one word.
  function automatic int fill_level(input logic [rp_pkg::PHASE_W-1:0] ph, input logic third);
    int steps;
    steps = (!third && ph > 3'd3) ? 3 : int'(ph);
    return ((third ? 48 : 96) * steps) % 128;
  endfunction

  function automatic logic [127:0] ones_below(input int n);
    logic [127:0] all;
    all = '1;
    return ~(all << n);
  endfunction

  task automatic pack_pixels(input rp_pkg::pix_item_t item, input bit queue_it);
    logic [127:0]               data;
    logic [127:0]               merged;
    logic [127:0]               rest;
    logic [rp_pkg::PHASE_W-1:0] nphase;
    int                         fill;
    int                         width;
    int                         n;
    int                         k;
    rp_pkg::word_item_t         w [2];
    data = mode_third ? {80'd0, item.pixels_lo} : {32'd0, item.pixels_hi, item.pixels_lo};
    width = mode_third ? 48 : 96;
    fill = fill_level(held_phase, mode_third);
    merged = (data << fill) | ({16'd0, held_bits} & ones_below(fill));
    n = 0;
    if (fill + width >= 128) begin
      w[0].word_lo = merged[63:0];
      w[0].word_hi = merged[127:64];
      w[0].final_word = 1'b0;
      n = 1;
      rest = data >> (128 - fill);
    end else begin
      rest = merged;
    end
    rest[127:rp_pkg::HOLD_W] = '0;
    if (mode_third) nphase = held_phase + 3'd1;
    else nphase = (held_phase >= rp_pkg::HALF_LAST_PHASE) ? 3'd0 : held_phase + 3'd1;
    if (item.frame_last) begin
      // flush the partial word, zero above its valid bits
      if (nphase != 3'd0) begin
        rest = rest & ones_below(fill_level(nphase, mode_third));
        w[n].word_lo = rest[63:0];
        w[n].word_hi = rest[127:64];
        w[n].final_word = 1'b0;
        n++;
      end
      if (n > 0) w[n-1].final_word = 1'b1;
      held_bits = '0;
      held_phase = '0;
    end else begin
      held_bits = rest[rp_pkg::HOLD_W-1:0];
      held_phase = nphase;
    end
    if (queue_it) for (k = 0; k < n; k++) words_due.push_back(w[k]);
  endtask

  task automatic send_item(input rp_pkg::pix_item_t item, input bit typed);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    pixel_data <= item;
    do @(posedge clk); while (full);
    pack_pixels(item, !typed);
  endtask

  // Hold the sender until all words are out, then let items with no word finish.
  task automatic settle_out();
    push <= 1'b0;
    while (words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input logic third);
    logic [rp_pkg::PDATA_W-1:0] rd;
    settle_out();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODE_ADDR;
    pwdata <= rp_pkg::PDATA_W'(third);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mode_third = third;
    // read back in a back-to-back transfer
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== rp_pkg::PDATA_W'(third))
      flag_mismatch("third_mode readback", rd, rp_pkg::PDATA_W'(third));
  endtask

  function automatic logic [47:0] pick_pixels();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return 48'({$urandom(), $urandom()});
    endcase
  endfunction

  always @(posedge clk) begin : receiver
    rp_pkg::word_item_t due;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (words_due.size() == 0) begin
          flag_mismatch("word with none due", {packed_word.word_hi, packed_word.word_lo}, '0);
        end else begin
          due = words_due.pop_front();
          if (packed_word.word_lo !== due.word_lo)
            flag_mismatch("word_lo", packed_word.word_lo, due.word_lo);
          if (packed_word.word_hi !== due.word_hi)
            flag_mismatch("word_hi", packed_word.word_hi, due.word_hi);
          if (packed_word.final_word !== due.final_word)
            flag_mismatch("final_word", packed_word.final_word, due.final_word);
        end
      end
      pop <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stalled_cycles <= 0;
    else stalled_cycles <= stalled_cycles + 1;
    if (stalled_cycles == STALL_LIMIT) begin
      $display("tb_result_packer_48_96_to_128_top NOT OK");
      $finish;
    end
  end

  initial begin
    rp_pkg::pix_item_t item;
    int                sent;
    int                len;
    int                frames;
    int                k;
    int                i;
    bit                leave_open;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_ROWS; i++) begin
      if (DIRECTED[i].third != mode_third) set_mode(DIRECTED[i].third);
      send_item(DIRECTED[i].item, DIRECTED[i].has_want);
      if (DIRECTED[i].has_want) words_due.push_back(DIRECTED[i].want);
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_mode(1'($urandom_range(0, 1)));
      frames = $urandom_range(1, 6);
      repeat (frames) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 40) : $urandom_range(1, 12);
        // an open frame carries its held bits into the next frame, maybe under a new mode
        leave_open = ($urandom_range(0, 9) == 0);
        for (k = 0; k < len; k++) begin
          item.pixels_lo = pick_pixels();
          item.pixels_hi = pick_pixels();
          item.frame_last = (k == len - 1) && !leave_open;
          if ($urandom_range(0, 49) == 0) item.frame_last = 1'b1;
          send_item(item, 1'b0);
          sent++;
          calm = (sent >= 400 && sent < 600);
          if (sent == 800) settle_out();
        end
      end
    end

    settle_out();
    repeat (20) @(posedge clk);
    if (errors == 0 && words_due.size() == 0) begin
      $display("tb_result_packer_48_96_to_128_top OK");
    end else begin
      $display("tb_result_packer_48_96_to_128_top NOT OK");
    end
    $finish;
  end

endmodule
